@@ src/bucketed_hash_table_macros.svh @@
// Assertion macros used by the checker file.
`ifndef BUCKETED_HASH_TABLE_MACROS_SVH
`define BUCKETED_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define BHT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define BHT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define BHT_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/bht_pkg.sv @@
`default_nettype none

package bht_pkg;

  localparam int BUCKET_BITS_DEF = 12;
  localparam int WAYS_DEF        = 8;
  localparam int KEY_BITS_DEF    = 48;
  localparam int VALUE_BITS_DEF  = 48;

  localparam int OUT_VALUE_W   = 48;
  localparam int EXT_W         = 64;
  localparam int STATUS_W      = 3;
  localparam int HASH_SHIFT_LO = 4;
  localparam int HASH_SHIFT_HI = 24;
  // Wide enough for a way index at the largest supported way count.
  localparam int WAY_IDX_W     = 4;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_INSERTED  = 3'd0;
  localparam status_t ST_FOUND     = 3'd1;
  localparam status_t ST_NOT_FOUND = 3'd2;
  localparam status_t ST_FULL      = 3'd3;
  localparam status_t ST_ZERO_KEY  = 3'd4;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  typedef struct packed {
    logic                 hit;
    logic [WAY_IDX_W-1:0] way;
  } match_t;

endpackage

`default_nettype wire

@@ src/bht_req_if.sv @@
`default_nettype none

interface bht_req_if #(
  parameter int KEY_BITS   = bht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS = bht_pkg::VALUE_BITS_DEF
) ();
  logic                  valid;
  logic                  ready;
  logic                  cmd;
  logic [KEY_BITS-1:0]   key;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output cmd, output key, output value, input ready);
  modport sink   (input valid, input cmd, input key, input value, output ready);
endinterface

`default_nettype wire

@@ src/bht_rsp_if.sv @@
`default_nettype none

interface bht_rsp_if ();
  logic                                valid;
  logic                                ready;
  bht_pkg::status_t                    status;
  logic [bht_pkg::OUT_VALUE_W-1:0]     value_out;

  modport source (output valid, output status, output value_out, input ready);
  modport sink   (input valid, input status, input value_out, output ready);
endinterface

`default_nettype wire

@@ src/bht_ram.sv @@
`default_nettype none

module bht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ src/bht_match.sv @@
`default_nettype none

module bht_match #(
  parameter int WAYS     = bht_pkg::WAYS_DEF,
  parameter int KEY_BITS = bht_pkg::KEY_BITS_DEF,
  parameter int CNT_W    = $clog2(WAYS + 1)
) (
  input  logic [KEY_BITS-1:0]            key,
  input  logic [WAYS-1:0][KEY_BITS-1:0]  keys,
  input  logic [CNT_W-1:0]               count,
  output bht_pkg::match_t                match
);

  localparam int WIW = bht_pkg::WAY_IDX_W;

  // Ways at or above the fill count were never written and must not match.
  // Scanning downward leaves the lowest matching way in the result.
  always_comb begin
    match = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (keys[w] == key && CNT_W'(w) < count) begin
        match.hit = 1'b1;
        match.way = WIW'(w);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/bucketed_hash_table.sv @@
// Each word is taken in S_IDLE, which also starts the read of its bucket row; its result
// is registered in S_LOOK once the result register is free. No new word is taken until
// then; on insert with a nonzero key into a bucket that is not full, S_LOOK writes the row back.
// Reset: synchronous; afterwards a clearing pass zeroes the per-bucket fill counts,
// one bucket per cycle through every bucket, while req.ready stays low.
`default_nettype none

module bucketed_hash_table #(
  parameter int BUCKET_BITS = bht_pkg::BUCKET_BITS_DEF,
  parameter int WAYS        = bht_pkg::WAYS_DEF,
  parameter int KEY_BITS    = bht_pkg::KEY_BITS_DEF,
  parameter int VALUE_BITS  = bht_pkg::VALUE_BITS_DEF
) (
  input logic        clk,
  input logic        rst,
  bht_req_if.sink    req,
  bht_rsp_if.source  rsp
);

  localparam int ROW_COUNT   = 1 << BUCKET_BITS;
  localparam int CNT_W       = $clog2(WAYS + 1);
  localparam int WIDX_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SLOT_W      = KEY_BITS + VALUE_BITS;
  localparam int ROW_W       = WAYS * SLOT_W;
  localparam int OUT_W       = bht_pkg::OUT_VALUE_W;
  localparam int EXT_W       = bht_pkg::EXT_W;

  bht_pkg::state_t state, state_next;

  logic [BUCKET_BITS-1:0] clr_addr;
  logic [BUCKET_BITS-1:0] bucket;
  logic                   cmd_q;
  logic [KEY_BITS-1:0]    key_q;
  logic [VALUE_BITS-1:0]  value_q;

  logic                   rsp_valid_q;
  bht_pkg::status_t       status_q;
  logic [OUT_W-1:0]       value_out_q;

  logic [KEY_BITS-1:0]    hash_sum;
  logic [BUCKET_BITS-1:0] req_bucket;
  logic [BUCKET_BITS-1:0] rd_addr;

  logic [ROW_W-1:0]                rd_row;
  logic [WAYS-1:0][SLOT_W-1:0]     row_q;
  logic [WAYS-1:0][SLOT_W-1:0]     row_new;
  logic [WAYS-1:0][KEY_BITS-1:0]   key_row;
  logic [WAYS-1:0][VALUE_BITS-1:0] val_row;
  logic [CNT_W-1:0]                cnt_q;

  logic                   row_we;
  logic                   cnt_we;
  logic [BUCKET_BITS-1:0] cnt_waddr;
  logic [CNT_W-1:0]       cnt_wdata;
  logic                   load;

  bht_pkg::match_t        match;
  logic                   zero_key;
  logic                   full;
  logic [VALUE_BITS-1:0]  hit_val;
  logic [EXT_W-1:0]       hit_ext;
  bht_pkg::status_t       status_d;
  logic [OUT_W-1:0]       value_out_d;

  // Only the low bucket bits of the sum survive the mask.
  assign hash_sum   = (req.key >> bht_pkg::HASH_SHIFT_LO) + (req.key >> bht_pkg::HASH_SHIFT_HI);
  assign req_bucket = hash_sum[BUCKET_BITS-1:0];
  // Holding the address while a result waits keeps the row on the read port.
  assign rd_addr    = (state == bht_pkg::S_IDLE) ? req_bucket : bucket;

  bht_ram #(
    .WIDTH (ROW_W),
    .DEPTH (ROW_COUNT)
  ) u_row_ram (
    .clk   (clk),
    .we    (row_we),
    .waddr (bucket),
    .wdata (row_new),
    .raddr (rd_addr),
    .rdata (rd_row)
  );

  bht_ram #(
    .WIDTH (CNT_W),
    .DEPTH (ROW_COUNT)
  ) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_q)
  );

  assign row_q = rd_row;

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      key_row[w] = row_q[w][SLOT_W-1 -: KEY_BITS];
      val_row[w] = row_q[w][VALUE_BITS-1:0];
    end
  end

  bht_match #(
    .WAYS     (WAYS),
    .KEY_BITS (KEY_BITS),
    .CNT_W    (CNT_W)
  ) u_match (
    .key   (key_q),
    .keys  (key_row),
    .count (cnt_q),
    .match (match)
  );

  // Ways fill in order, so the first free way is the fill count itself.
  always_comb begin
    row_new = row_q;
    row_new[cnt_q[WIDX_W-1:0]] = {key_q, value_q};
  end

  assign zero_key = (key_q == '0);
  assign full     = (cnt_q >= CNT_W'(WAYS));
  assign hit_val  = val_row[match.way[WIDX_W-1:0]];
  assign hit_ext  = EXT_W'(hit_val);

  always_comb begin
    status_d    = bht_pkg::ST_NOT_FOUND;
    value_out_d = '0;
    if (zero_key) begin
      status_d = bht_pkg::ST_ZERO_KEY;
    end else if (cmd_q == bht_pkg::CMD_INSERT) begin
      status_d = full ? bht_pkg::ST_FULL : bht_pkg::ST_INSERTED;
    end else if (match.hit) begin
      status_d    = bht_pkg::ST_FOUND;
      value_out_d = hit_ext[OUT_W-1:0];
    end
  end

  always_comb begin
    state_next = state;
    req.ready  = 1'b0;
    load       = 1'b0;
    row_we     = 1'b0;
    cnt_we     = 1'b0;
    cnt_waddr  = bucket;
    cnt_wdata  = cnt_q + CNT_W'(1);
    case (state)
      bht_pkg::S_CLEAR: begin
        cnt_we    = 1'b1;
        cnt_waddr = clr_addr;
        cnt_wdata = '0;
        if (clr_addr == '1) begin
          state_next = bht_pkg::S_IDLE;
        end
      end
      bht_pkg::S_IDLE: begin
        req.ready = 1'b1;
        if (req.valid) begin
          state_next = bht_pkg::S_LOOK;
        end
      end
      bht_pkg::S_LOOK: begin
        if (!rsp_valid_q || rsp.ready) begin
          load       = 1'b1;
          state_next = bht_pkg::S_IDLE;
          if (!zero_key && cmd_q == bht_pkg::CMD_INSERT && !full) begin
            row_we = 1'b1;
            cnt_we = 1'b1;
          end
        end
      end
      default: begin
        state_next = bht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= bht_pkg::S_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == bht_pkg::S_CLEAR) begin
        clr_addr <= clr_addr + BUCKET_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      bucket  <= req_bucket;
      cmd_q   <= req.cmd;
      key_q   <= req.key;
      value_q <= req.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid_q <= 1'b0;
    end else if (load) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status_q    <= status_d;
      value_out_q <= value_out_d;
    end
  end

  assign rsp.valid     = rsp_valid_q;
  assign rsp.status    = status_q;
  assign rsp.value_out = value_out_q;

endmodule

`default_nettype wire

@@ src/bht_checker.sv @@
`default_nettype none
`include "bucketed_hash_table_macros.svh"

module bht_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            req_valid,
  input logic                            req_ready,
  input logic                            rsp_valid,
  input logic                            rsp_ready,
  input bht_pkg::status_t                status,
  input logic [bht_pkg::OUT_VALUE_W-1:0] value_out
);

  // A held result word must not change under backpressure.
  `BHT_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(value_out), "result word changed while stalled")

  // The table works on one word at a time.
  `BHT_ASSERT_NXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while a word is in flight")

  // Only a hit carries a value.
  `BHT_ASSERT_IMP(a_value_zero, rsp_valid && status != bht_pkg::ST_FOUND, value_out == '0, "nonzero value on a result that is not a hit")

  // Reset leaves no result pending and no request taken.
  `BHT_ASSERT_RST(a_reset_quiet, rst, !rsp_valid && !req_ready, "port active right after reset")

endmodule

bind bucketed_hash_table bht_checker u_bht_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .status    (rsp.status),
  .value_out (rsp.value_out)
);

`default_nettype wire

@@ sim/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bht_pkg::*;

  localparam int BUCKET_BITS = BUCKET_BITS_DEF;
  localparam int WAYS        = WAYS_DEF;
  localparam int KEY_BITS    = KEY_BITS_DEF;
  localparam int VALUE_BITS  = VALUE_BITS_DEF;
  localparam int NUM_SLOTS   = (1 << BUCKET_BITS) * WAYS;

  localparam int HOT_BUCKETS    = 24;
  localparam int PHASE_WORDS    = 350;
  localparam int HOLD_WORDS     = 80;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 10;
  // The clearing pass after reset, one bucket at a time through every bucket, alone keeps the request side closed.
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    status_t                status;
    logic [OUT_VALUE_W-1:0] value_out;
  } answer_t;

  typedef struct packed {
    logic                   cmd;
    logic [KEY_BITS-1:0]    key;
    logic [VALUE_BITS-1:0]  value;
    logic                   fixed;
    status_t                status;
    logic [OUT_VALUE_W-1:0] value_out;
  } row_t;

  // Rows with fixed set carry an answer that is obvious by inspection; the rest go
  // through the shadow table.
  localparam row_t DIRECTED [22] = '{
    '{CMD_LOOKUP, 48'h0000_0000_0001, 48'h0000_0000_0000, 1'b1, ST_NOT_FOUND, 48'h0},
    '{CMD_INSERT, 48'h0000_0000_0000, 48'hFFFF_FFFF_FFFF, 1'b1, ST_ZERO_KEY,  48'h0},
    '{CMD_LOOKUP, 48'h0000_0000_0000, 48'h5A5A_5A5A_5A5A, 1'b1, ST_ZERO_KEY,  48'h0},
    '{CMD_INSERT, 48'hFFFF_FFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1, ST_INSERTED,  48'h0},
    '{CMD_LOOKUP, 48'hFFFF_FFFF_FFFF, 48'h0000_0000_0000, 1'b1, ST_FOUND,
      48'hFFFF_FFFF_FFFF},
    '{CMD_INSERT, 48'h0000_0000_0001, 48'h0000_0000_0000, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_LOOKUP, 48'h0000_0000_0001, 48'hFFFF_FFFF_FFFF, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0010_0000_0010, 48'h0000_0000_0101, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0020_0000_0010, 48'h0000_0000_0202, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0030_0000_0010, 48'h0000_0000_0303, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0040_0000_0010, 48'h0000_0000_0404, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0050_0000_0010, 48'h0000_0000_0505, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0060_0000_0010, 48'h0000_0000_0606, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0070_0000_0010, 48'h0000_0000_0707, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0080_0000_0010, 48'h0000_0000_0808, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0090_0000_0010, 48'h0000_0000_0909, 1'b1, ST_FULL,      48'h0},
    '{CMD_LOOKUP, 48'h00A0_0000_0010, 48'h0000_0000_0000, 1'b1, ST_NOT_FOUND, 48'h0},
    '{CMD_LOOKUP, 48'h0080_0000_0010, 48'h0000_0000_0000, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0000_0000_0020, 48'h1111_1111_1111, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h0000_0000_0020, 48'h2222_2222_2222, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_LOOKUP, 48'h0000_0000_0020, 48'h0000_0000_0000, 1'b0, ST_INSERTED,  48'h0},
    '{CMD_INSERT, 48'h8000_0000_0000, 48'h8000_0000_0001, 1'b0, ST_INSERTED,  48'h0}
  };

  localparam int PHASE_SRC_IDLE [4] = '{0, 66, 0, 22};
  localparam int PHASE_SNK_STALL[4] = '{0, 0, 66, 22};

  logic clk = 1'b0;
  logic rst;

  bht_req_if req ();
  bht_rsp_if rsp ();

  bucketed_hash_table #(
    .BUCKET_BITS (BUCKET_BITS),
    .WAYS        (WAYS),
    .KEY_BITS    (KEY_BITS),
    .VALUE_BITS  (VALUE_BITS)
  ) u_top (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Shadow copy of the table contents.
  bit                    slot_used [NUM_SLOTS];
  logic [KEY_BITS-1:0]   slot_key  [NUM_SLOTS];
  logic [VALUE_BITS-1:0] slot_value[NUM_SLOTS];

  answer_t answers_due[$];
  logic    row_fixed;
  answer_t row_answer;

  int mismatch_count = 0;
  int words_sent     = 0;
  int status_seen [5];

  int   src_idle_pct  = 0;
  int   snk_stall_pct = 0;
  logic hold_toggle   = 1'b0;
  logic hold_seen     = 1'b0;
  int   hold_left     = 0;
  int   quiet_cycles  = 0;

  logic [BUCKET_BITS-1:0] hot_bucket [HOT_BUCKETS];
  logic [KEY_BITS-1:0]    issued_keys[$];

  function automatic answer_t shadow_access(logic cmd, logic [KEY_BITS-1:0] key,
                                            logic [VALUE_BITS-1:0] value);
    answer_t     ans;
    logic [63:0] hash;
    int          base;
    bit          done;
    ans.status    = ST_ZERO_KEY;
    ans.value_out = '0;
    done          = 1'b0;
    if (key != '0) begin
      hash = (64'(key) >> HASH_SHIFT_LO) + (64'(key) >> HASH_SHIFT_HI);
      base = int'(hash[BUCKET_BITS-1:0]) * WAYS;
      ans.status = (cmd == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
      for (int w = 0; w < WAYS; w++) begin
        if (!done && cmd == CMD_INSERT && !slot_used[base + w]) begin
          slot_used[base + w]  = 1'b1;
          slot_key[base + w]   = key;
          slot_value[base + w] = value;
          ans.status           = ST_INSERTED;
          done                 = 1'b1;
        end else if (!done && cmd == CMD_LOOKUP && slot_used[base + w] &&
                     slot_key[base + w] == key) begin
          ans.status    = ST_FOUND;
          ans.value_out = slot_value[base + w][OUT_VALUE_W-1:0];
          done          = 1'b1;
        end
      end
    end
    return ans;
  endfunction

  function automatic logic [47:0] random48();
    logic [63:0] raw;
    raw = {$urandom(), $urandom()};
    return raw[47:0];
  endfunction

  // A random key whose hash lands in the given bucket.
  function automatic logic [KEY_BITS-1:0] key_in_bucket(logic [BUCKET_BITS-1:0] bucket);
    logic [KEY_BITS-1:0] k;
    k = random48();
    k[HASH_SHIFT_LO +: BUCKET_BITS] = bucket - k[HASH_SHIFT_HI +: BUCKET_BITS];
    return k;
  endfunction

  task automatic send_word(logic cmd, logic [KEY_BITS-1:0] key,
                           logic [VALUE_BITS-1:0] value, logic fixed, answer_t ans);
    while ($urandom_range(99) < src_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid  <= 1'b1;
    req.cmd    <= cmd;
    req.key    <= key;
    req.value  <= value;
    row_fixed  <= fixed;
    row_answer <= ans;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic pick_hot_buckets();
    foreach (hot_bucket[i]) hot_bucket[i] = BUCKET_BITS'($urandom());
  endtask

  // Mostly traffic that piles into a few buckets, so that fills, duplicates and
  // hits are common; the rest is zero keys and keys spread over the whole table.
  task automatic send_random_word();
    int                    pick;
    logic                  cmd;
    logic [KEY_BITS-1:0]   key;
    logic [VALUE_BITS-1:0] value;
    pick  = $urandom_range(99);
    value = random48();
    if (pick < 45 || (pick < 80 && issued_keys.size() == 0)) begin
      cmd = CMD_INSERT;
      key = key_in_bucket(hot_bucket[$urandom_range(HOT_BUCKETS - 1)]);
    end else if (pick < 50) begin
      cmd = CMD_INSERT;
      key = issued_keys[$urandom_range(issued_keys.size() - 1)];
    end else if (pick < 80) begin
      cmd = CMD_LOOKUP;
      key = issued_keys[$urandom_range(issued_keys.size() - 1)];
    end else if (pick < 90) begin
      cmd = CMD_LOOKUP;
      key = key_in_bucket(hot_bucket[$urandom_range(HOT_BUCKETS - 1)]);
    end else if (pick < 94) begin
      cmd = 1'($urandom_range(1));
      key = '0;
    end else begin
      cmd = 1'($urandom_range(1));
      key = random48();
    end
    if (cmd == CMD_INSERT && key != '0) issued_keys.push_back(key);
    send_word(cmd, key, value, 1'b0, '0);
  endtask

  task automatic drain_answers();
    req.valid <= 1'b0;
    @(posedge clk);
    while (answers_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rsp.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_toggle != hold_seen) begin
      rsp.ready <= 1'b0;
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES;
    end else begin
      rsp.ready <= ($urandom_range(99) >= snk_stall_pct);
    end
  end

  // Results are checked before the word accepted at the same edge is predicted.
  always @(posedge clk) begin : check_words
    answer_t want;
    answer_t calc;
    if (!rst) begin
      if (rsp.valid && rsp.ready) begin
        if (answers_due.size() == 0) begin
          $error("result word with no word outstanding: status %0d, value_out %0h",
                 rsp.status, rsp.value_out);
          mismatch_count++;
        end else begin
          want = answers_due.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            mismatch_count++;
          end
          if (rsp.value_out !== want.value_out) begin
            $error("value_out: expected %0h, got %0h", want.value_out, rsp.value_out);
            mismatch_count++;
          end
        end
      end
      if (req.valid && req.ready) begin
        calc = shadow_access(req.cmd, req.key, req.value);
        answers_due.push_back(row_fixed ? row_answer : calc);
        status_seen[calc.status]++;
      end
    end
  end

  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst        <= 1'b1;
    req.valid  <= 1'b0;
    req.cmd    <= CMD_INSERT;
    req.key    <= '0;
    req.value  <= '0;
    row_fixed  <= 1'b0;
    row_answer <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i])
      send_word(DIRECTED[i].cmd, DIRECTED[i].key, DIRECTED[i].value, DIRECTED[i].fixed,
                '{DIRECTED[i].status, DIRECTED[i].value_out});
    drain_answers();

    for (int p = 0; p < 4; p++) begin
      src_idle_pct  = PHASE_SRC_IDLE[p];
      snk_stall_pct <= PHASE_SNK_STALL[p];
      pick_hot_buckets();
      repeat (PHASE_WORDS) send_random_word();
      drain_answers();
    end

    // Long receiver hold-off while words keep coming, so the block backs up
    // into its request side.
    src_idle_pct  = 0;
    snk_stall_pct <= 0;
    hold_toggle   <= ~hold_toggle;
    pick_hot_buckets();
    repeat (HOLD_WORDS) send_random_word();
    drain_answers();

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d words: %0d inserted, %0d found, %0d not found, %0d full, %0d zero key.",
             words_sent, status_seen[ST_INSERTED], status_seen[ST_FOUND],
             status_seen[ST_NOT_FOUND], status_seen[ST_FULL], status_seen[ST_ZERO_KEY]);
    $display("Idle patterns: none, sender, receiver, both, plus one long receiver hold-off.");
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+src
src/bht_pkg.sv
src/bht_req_if.sv
src/bht_rsp_if.sv
src/bht_ram.sv
src/bht_match.sv
src/bucketed_hash_table.sv
src/bht_checker.sv
sim/testbench.sv
